/* hw/rtl/kf2d_pkg.sv */
package kf2d_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_EX,
    OP_EY,
    OP_COV,
    OP_PX,
    OP_PY
  } op_t;

  typedef struct packed {
    logic clr_gain;
    logic clr_all;
  } cfg_evt_t;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_PROC_VAR = 2'd0;
  localparam logic [1:0] REG_MEAS_VAR = 2'd1;
  localparam logic [1:0] REG_STEP_INT = 2'd2;

endpackage

/* hw/rtl/kalman_filter_2d_position.sv */
// A new sample is taken only in the idle state, after the previous estimate has been loaded
// into the output registers; sample_stall is high in every other state.
// Five products go one after another through a single 33x33 multiplier in multiply, round
// and accumulate steps; the gain comes from a restoring divider, one quotient bit per cycle.
// Synchronous reset restores the register defaults and clears position, covariance and gain.
module kalman_filter_2d_position #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  logic signed [31:0]          meas_x,
  input  logic signed [31:0]          meas_y,
  input  logic signed [31:0]          ctrl_x,
  input  logic signed [31:0]          ctrl_y,
  output logic                        est_valid,
  input  logic                        est_stall,
  output logic signed [31:0]          est_x,
  output logic signed [31:0]          est_y,
  output logic                        saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kf2d_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  import kf2d_pkg::*;

  localparam int unsigned GW = FRAC_BITS + 1;
  localparam logic [GW-1:0] ONE = GW'(64'd1 << FRAC_BITS);
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic [31:0] Q_RESET = 32'(((64'd6 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [31:0] R_RESET = 32'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] T_RESET = 32'(((64'd25 << FRAC_BITS) + 64'd5000) / 64'd10000);

  state_t state;
  state_t state_next;
  op_t    op;
  op_t    op_next;

  logic signed [31:0] pred_x;
  logic signed [31:0] pred_y;
  logic [31:0]        error_cov;
  logic [GW-1:0]      gain;

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] ex;
  logic signed [31:0] ey;
  logic               sat;
  logic               den_zero;

  logic [31:0] proc_var;
  logic [31:0] meas_var;
  logic [31:0] step_int;
  cfg_evt_t    evt;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic signed [65:0] rnd;
  logic signed [31:0] base;
  logic signed [66:0] sum;
  logic [32:0]        clamped;
  logic [32:0]        csum;
  logic [GW-1:0]      one_minus_gain;

  logic          div_start;
  logic          div_done;
  logic [32:0]   div_den;
  logic [GW-1:0] quot;

  logic accept;
  logic load_out;

  function automatic logic [32:0] clamp_s32(input logic signed [66:0] v);
    logic [32:0] r;
    if (v > 67'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -67'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  kf2d_regs #(
    .Q_RESET(Q_RESET),
    .R_RESET(R_RESET),
    .T_RESET(T_RESET)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .proc_var(proc_var),
    .meas_var(meas_var),
    .step_int(step_int),
    .evt     (evt)
  );

  assign pready = 1'b1;

  assign one_minus_gain = ONE - gain;

  always_comb begin
    case (op)
      OP_EX: begin
        mul_a = dx;
        mul_b = $signed({{(33 - GW){1'b0}}, gain});
      end
      OP_EY: begin
        mul_a = dy;
        mul_b = $signed({{(33 - GW){1'b0}}, gain});
      end
      OP_COV: begin
        mul_a = $signed({1'b0, error_cov});
        mul_b = $signed({{(33 - GW){1'b0}}, one_minus_gain});
      end
      OP_PX: begin
        mul_a = $signed({1'b0, step_int});
        mul_b = {cx[31], cx};
      end
      OP_PY: begin
        mul_a = $signed({1'b0, step_int});
        mul_b = {cy[31], cy};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  kf2d_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  always_comb begin
    case (op)
      OP_EX:   base = pred_x;
      OP_EY:   base = pred_y;
      OP_PX:   base = ex;
      OP_PY:   base = ey;
      default: base = '0;
    endcase
  end

  assign sum     = $signed({{35{base[31]}}, base}) + $signed({rnd[65], rnd});
  assign clamped = clamp_s32(sum);
  assign csum    = {1'b0, rnd[31:0]} + {1'b0, proc_var};

  assign div_start = (state == ST_DIV_LOAD);
  assign div_den   = {1'b0, error_cov} + {1'b0, meas_var};

  kf2d_div #(
    .QW(GW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (error_cov),
    .den  (div_den),
    .done (div_done),
    .quot (quot)
  );

  assign accept   = sample_valid && !sample_stall;
  assign load_out = (state == ST_FINISH) && (!est_valid || !est_stall);

  always_comb begin
    state_next   = state;
    op_next      = op;
    sample_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = ST_MUL;
          op_next    = OP_EX;
        end
      end
      ST_MUL: state_next = ST_RND;
      ST_RND: state_next = ST_ACC;
      ST_ACC: begin
        case (op)
          OP_EX:   begin op_next = OP_EY;  state_next = ST_MUL; end
          OP_EY:   begin op_next = OP_COV; state_next = ST_MUL; end
          OP_COV:  begin op_next = OP_PX;  state_next = ST_MUL; end
          OP_PX:   begin op_next = OP_PY;  state_next = ST_MUL; end
          default: state_next = ST_DIV_LOAD;
        endcase
      end
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!est_valid || !est_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_EX;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_x    <= '0;
      pred_y    <= '0;
      error_cov <= '0;
      gain      <= '0;
    end else if (evt.clr_all) begin
      pred_x    <= '0;
      pred_y    <= '0;
      error_cov <= '0;
      gain      <= '0;
    end else if (evt.clr_gain) begin
      gain <= '0;
    end else begin
      if (state == ST_ACC) begin
        case (op)
          OP_COV:  error_cov <= csum[32] ? 32'hFFFF_FFFF : csum[31:0];
          OP_PX:   pred_x <= clamped[31:0];
          OP_PY:   pred_y <= clamped[31:0];
          default: error_cov <= error_cov;
        endcase
      end
      if (load_out) begin
        gain <= den_zero ? '0 : quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx  <= {meas_x[31], meas_x} - {pred_x[31], pred_x};
      dy  <= {meas_y[31], meas_y} - {pred_y[31], pred_y};
      cx  <= ctrl_x;
      cy  <= ctrl_y;
      sat <= 1'b0;
    end else if (state == ST_ACC) begin
      case (op)
        OP_EX: begin
          ex  <= clamped[31:0];
          sat <= sat | clamped[32];
        end
        OP_EY: begin
          ey  <= clamped[31:0];
          sat <= sat | clamped[32];
        end
        OP_COV:  sat <= sat | csum[32];
        default: sat <= sat | clamped[32];
      endcase
    end
    if (state == ST_RND) begin
      rnd <= (prod + HALF) >>> FRAC_BITS;
    end
    if (div_start) begin
      den_zero <= (div_den == 33'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
    end else if (load_out) begin
      est_valid <= 1'b1;
    end else if (!est_stall) begin
      est_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      est_x     <= ex;
      est_y     <= ey;
      saturated <= sat;
    end
  end

  a_gain_bound: assert property (@(posedge clk) disable iff (rst) gain <= ONE)
    else $error("gain exceeds one");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(est_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside the finish step");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished while the sequencer was not waiting");

endmodule

/* hw/rtl/kf2d_mul.sv */
module kf2d_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* hw/rtl/kf2d_div.sv */
module kf2d_div #(
  parameter int unsigned QW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   num,
  input  logic [32:0]   den,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [33:0]   rem;
  logic [32:0]   den_r;
  logic [CW-1:0] cnt;
  logic          run;
  logic          ge;
  logic [33:0]   rem_sub;

  always_comb begin
    ge      = rem >= {1'b0, den_r};
    rem_sub = ge ? (rem - {1'b0, den_r}) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run) begin
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {2'b00, num};
      den_r <= den;
      cnt   <= CW'(QW);
      quot  <= '0;
    end else if (run) begin
      rem  <= {rem_sub[32:0], 1'b0};
      quot <= {quot[QW-2:0], ge};
      cnt  <= cnt - CW'(1);
    end
  end

endmodule

/* hw/rtl/kf2d_regs.sv */
module kf2d_regs #(
  parameter logic [31:0] Q_RESET = 32'd3932,
  parameter logic [31:0] R_RESET = 32'd19661,
  parameter logic [31:0] T_RESET = 32'd164
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kf2d_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic [31:0]                proc_var,
  output logic [31:0]                meas_var,
  output logic [31:0]                step_int,
  output kf2d_pkg::cfg_evt_t         evt
);

  import kf2d_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_comb begin
    evt.clr_gain = 1'b0;
    evt.clr_all  = 1'b0;
    if (wr) begin
      case (idx)
        REG_PROC_VAR: evt.clr_gain = 1'b1;
        REG_MEAS_VAR: evt.clr_gain = 1'b1;
        REG_STEP_INT: evt.clr_all  = 1'b1;
        default:      evt.clr_all  = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_var <= Q_RESET;
      meas_var <= R_RESET;
      step_int <= T_RESET;
    end else if (wr) begin
      case (idx)
        REG_PROC_VAR: proc_var <= pwdata;
        REG_MEAS_VAR: meas_var <= pwdata;
        REG_STEP_INT: begin
          step_int <= pwdata;
          proc_var <= Q_RESET;
          meas_var <= R_RESET;
        end
        default: proc_var <= proc_var;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROC_VAR: prdata = proc_var;
      REG_MEAS_VAR: prdata = meas_var;
      REG_STEP_INT: prdata = step_int;
      default:      prdata = 32'd0;
    endcase
  end

endmodule

/* test/tb_kalman_filter_2d_position.sv */
module tb_kalman_filter_2d_position;
  import kf2d_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 20;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam logic [31:0] Q_DEFAULT = 32'd3932;
  localparam logic [31:0] R_DEFAULT = 32'd19661;
  localparam logic [31:0] T_DEFAULT = 32'd164;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh80000000;
  localparam longint LIM_MAX = 64'sd2147483647;
  localparam longint LIM_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } sample_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic sat;
  } est_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [31:0] meas_x = '0;
  logic signed [31:0] meas_y = '0;
  logic signed [31:0] ctrl_x = '0;
  logic signed [31:0] ctrl_y = '0;
  logic est_valid;
  logic est_stall = 1'b0;
  logic signed [31:0] est_x;
  logic signed [31:0] est_y;
  logic saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  kalman_filter_2d_position dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .meas_x(meas_x),
    .meas_y(meas_y),
    .ctrl_x(ctrl_x),
    .ctrl_y(ctrl_y),
    .est_valid(est_valid),
    .est_stall(est_stall),
    .est_x(est_x),
    .est_y(est_y),
    .saturated(saturated),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Filter state and register copies kept by the testbench.
  logic [31:0] q_var = Q_DEFAULT;
  logic [31:0] r_var = R_DEFAULT;
  logic [31:0] dt = T_DEFAULT;
  logic signed [31:0] track_x = '0;
  logic signed [31:0] track_y = '0;
  logic [31:0] shared_cov = '0;
  logic [16:0] shared_gain = '0;
  bit step_sat;

  est_t est_queue[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  function automatic longint round_q(longint v);
    return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [31:0] clamp_s32(longint v);
    if (v > LIM_MAX) begin
      step_sat = 1'b1;
      return POS_MAX;
    end
    if (v < LIM_MIN) begin
      step_sat = 1'b1;
      return POS_MIN;
    end
    return v[31:0];
  endfunction

  function automatic est_t filter_step(sample_t s);
    longint g;
    longint unsigned c;
    longint unsigned denom;
    est_t r;
    step_sat = 1'b0;
    g = longint'(shared_gain);
    r.x = clamp_s32(longint'(track_x) + round_q(g * (longint'(s.mx) - longint'(track_x))));
    r.y = clamp_s32(longint'(track_y) + round_q(g * (longint'(s.my) - longint'(track_y))));
    c = ({32'd0, shared_cov} * ((64'd1 << FRAC) - {47'd0, shared_gain})
         + (64'd1 << (FRAC - 1))) >> FRAC;
    track_x = clamp_s32(longint'(r.x) + round_q(longint'({32'd0, dt}) * longint'(s.cx)));
    track_y = clamp_s32(longint'(r.y) + round_q(longint'({32'd0, dt}) * longint'(s.cy)));
    c = c + {32'd0, q_var};
    if (c > 64'hFFFFFFFF) begin
      c = 64'hFFFFFFFF;
      step_sat = 1'b1;
    end
    shared_cov = c[31:0];
    denom = c + {32'd0, r_var};
    if (denom == 0) shared_gain = '0;
    else shared_gain = 17'((c << FRAC) / denom);
    r.sat = step_sat;
    return r;
  endfunction

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_PROC_VAR: return q_var;
      REG_MEAS_VAR: return r_var;
      REG_STEP_INT: return dt;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_field(int scale);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return int'($urandom_range(2 * scale)) - scale;
    if (pick < 80) return $urandom;
    case ($urandom_range(4))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.mx = pick_field(1 << 21);
    s.my = pick_field(1 << 21);
    s.cx = pick_field(1 << 18);
    s.cy = pick_field(1 << 18);
    return s;
  endfunction

  function automatic sample_t make_sample(logic signed [31:0] mx, logic signed [31:0] my,
                                          logic signed [31:0] cx, logic signed [31:0] cy);
    sample_t s;
    s.mx = mx;
    s.my = my;
    s.cx = cx;
    s.cy = cy;
    return s;
  endfunction

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    meas_x <= s.mx;
    meas_y <= s.my;
    ctrl_x <= s.cx;
    ctrl_y <= s.cy;
    do @(negedge clk); while (sample_stall);
    @(posedge clk);
    est_queue.insert(est_queue.size(), filter_step(s));
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (est_queue.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PROC_VAR: begin
        q_var = val;
        shared_gain = '0;
      end
      REG_MEAS_VAR: begin
        r_var = val;
        shared_gain = '0;
      end
      REG_STEP_INT: begin
        dt = val;
        q_var = Q_DEFAULT;
        r_var = R_DEFAULT;
        track_x = '0;
        track_y = '0;
        shared_cov = '0;
        shared_gain = '0;
      end
      default: ;
    endcase
  endtask

  task automatic apb_read_check(logic [1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    if (prdata !== reg_value(idx)) begin
      $error("prdata: expected %0h, actual %0h", reg_value(idx), prdata);
      fail_count++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [31:0] t, logic [31:0] q, logic [31:0] r);
    apb_write(REG_STEP_INT, t);
    apb_write(REG_PROC_VAR, q);
    apb_write(REG_MEAS_VAR, r);
  endtask

  // The receiver either stalls at random or holds off for a fixed stretch on request.
  always @(posedge clk) begin
    if (hold_seen != hold_toggle) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      est_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      est_stall <= 1'b1;
    end else begin
      est_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    est_t want;
    if (!rst && est_valid && !est_stall) begin
      if (est_queue.size() == 0) begin
        $error("est: transaction with no sample pending");
        fail_count++;
      end else begin
        want = est_queue.pop_front();
        if (est_x !== want.x) begin
          $error("est_x: expected %0d, actual %0d", want.x, est_x);
          fail_count++;
        end
        if (est_y !== want.y) begin
          $error("est_y: expected %0d, actual %0d", want.y, est_y);
          fail_count++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %0b, actual %0b", want.sat, saturated);
          fail_count++;
        end
      end
    end
  end

  task automatic test_register_defaults();
    apb_read_check(REG_PROC_VAR);
    apb_read_check(REG_MEAS_VAR);
    apb_read_check(REG_STEP_INT);
    send_sample(make_sample(32'sd0, 32'sd0, 32'sd0, 32'sd0));
    send_sample(make_sample(32'sd65536, -32'sd65536, 32'sd131072, -32'sd131072));
    send_sample(make_sample(32'sd70000, -32'sd60000, 32'sd131072, -32'sd131072));
    wait_drained();
  endtask

  task automatic test_field_extremes();
    send_sample(make_sample(POS_MAX, POS_MIN, POS_MAX, POS_MIN));
    send_sample(make_sample(POS_MIN, POS_MAX, POS_MIN, POS_MAX));
    send_sample(make_sample(-32'sd1, 32'sd1, -32'sd1, 32'sd1));
    wait_drained();
    apb_write(REG_STEP_INT, 32'hFFFFFFFF);
    send_sample(make_sample(POS_MAX, POS_MAX, POS_MAX, POS_MAX));
    send_sample(make_sample(POS_MIN, POS_MIN, POS_MIN, POS_MIN));
    send_sample(make_sample(POS_MAX, POS_MIN, POS_MIN, POS_MAX));
    send_sample(make_sample(POS_MIN, POS_MAX, 32'sd0, 32'sd0));
    send_sample(make_sample(32'sd0, 32'sd0, 32'sd1, -32'sd1));
    wait_drained();
  endtask

  task automatic test_covariance_overflow();
    apply_settings(T_DEFAULT, 32'hFFFFFFFF, 32'hFFFFFFFF);
    repeat (3) send_sample(make_sample(32'sd100000, -32'sd100000, 32'sd65536, 32'sd65536));
    wait_drained();
  endtask

  task automatic test_zero_denominator();
    apply_settings(32'd65536, 32'd0, 32'd0);
    send_sample(make_sample(32'sd5000, 32'sd7000, 32'sd65536, -32'sd65536));
    send_sample(make_sample(-32'sd5000, -32'sd7000, 32'sd0, 32'sd0));
    send_sample(make_sample(POS_MAX, POS_MIN, 32'sd0, 32'sd0));
    wait_drained();
  endtask

  task automatic test_unknown_register();
    apb_write(REG_UNUSED, 32'hFFFFFFFF);
    apb_read_check(REG_PROC_VAR);
    apb_read_check(REG_MEAS_VAR);
    apb_read_check(REG_STEP_INT);
    send_sample(make_sample(32'sd300000, 32'sd400000, 32'sd1000, 32'sd2000));
    send_sample(make_sample(32'sd310000, 32'sd390000, 32'sd1000, 32'sd2000));
    wait_drained();
  endtask

  task automatic test_random_phases();
    int idle_set[4] = '{0, 60, 0, 31};
    int stall_set[4] = '{0, 0, 60, 31};
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apb_write(REG_STEP_INT, T_DEFAULT);
        1: apply_settings($urandom, $urandom, $urandom);
        2: apply_settings(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
        3: apply_settings(32'd0, 32'd0, 32'hFFFFFFFF);
        4: apply_settings($urandom_range(1 << 16), $urandom_range(1 << 17),
                          $urandom_range(1 << 17));
        5: apply_settings(32'd1, 32'd1, 32'd1);
        6: apply_settings($urandom, $urandom, $urandom);
        default: apply_settings(32'd65536, 32'd65536, 32'd65536);
      endcase
      send_idle_pct = idle_set[p % 4];
      recv_stall_pct = stall_set[p % 4];
      repeat (PHASE_ITEMS) send_sample(random_sample());
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    apb_write(REG_STEP_INT, T_DEFAULT);
    hold_toggle = !hold_toggle;
    repeat (20) send_sample(random_sample());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_field_extremes();
    test_covariance_overflow();
    test_zero_denominator();
    test_unknown_register();
    test_random_phases();
    test_backpressure();
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && est_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
